// File: sv/gbn_pkg.sv
package gbn_pkg;

  localparam int MAXB = 64;
  localparam int CW   = 24;
  localparam int AW   = $clog2(MAXB);
  localparam int CNTW = AW + 1;
  localparam int SCW  = 16;
  localparam int CLW  = 8;
  localparam int IOUW = 8;
  localparam int KW   = 7;
  localparam int SHW  = 15;
  localparam int OFW  = CLW + SHW;
  localparam int DW   = ((CW > OFW) ? CW : OFW) + 2;
  localparam int TDW  = ((4 * CW + SCW + 7) / 8) * 8;
  localparam int PAW  = 4;
  localparam int PDW  = 32;

  typedef enum logic [1:0] {
    REG_IOU   = 2'd0,
    REG_KEEP  = 2'd1,
    REG_SORT  = 2'd2,
    REG_SHIFT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CLW-1:0] cls;
    logic [SCW-1:0] score;
    logic [CW-1:0]  bottom;
    logic [CW-1:0]  right;
    logic [CW-1:0]  top;
    logic [CW-1:0]  left;
  } box_t;

  // Corner minus class offset, clamped to the signed coordinate range.
  function automatic logic [CW-1:0] sat_sub(input logic [CW-1:0] c,
                                            input logic [OFW-1:0] off);
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] lo;
    hi = {{(DW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    lo = ~hi;
    d  = DW'(signed'(c)) - DW'(signed'({1'b0, off}));
    if (d > hi) begin
      return hi[CW-1:0];
    end else if (d < lo) begin
      return lo[CW-1:0];
    end
    return d[CW-1:0];
  endfunction

endpackage

// File: sv/greedy_box_nms_core.sv
// Greedy box suppression core.
// Loading takes one box per cycle. After the box marked last, ranking by score makes one
// score memory read per pair of boxes (no pair reads with sorting off); then a kept box runs
// pair tests against every later entry through the single overlap unit, waiting for each
// result before the next pair. Reset (rst_ni low, asynchronous) empties the set and
// restores the register defaults.
module greedy_box_nms_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // Fields from bit 0 up: left, top, right, bottom, score.
  input  logic [gbn_pkg::TDW-1:0]   s_axis_tdata,
  // Fields from bit 0 up: class.
  input  logic [gbn_pkg::CLW-1:0]   s_axis_tuser,
  input  logic                      s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // Fields from bit 0 up: left, top, right, bottom, score.
  output logic [gbn_pkg::TDW-1:0]   m_axis_tdata,
  // Fields from bit 0 up: class.
  output logic [gbn_pkg::CLW-1:0]   m_axis_tuser,
  output logic                      m_axis_tlast,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [gbn_pkg::PAW-1:0]   paddr,
  input  logic [gbn_pkg::PDW-1:0]   pwdata,
  output logic [gbn_pkg::PDW-1:0]   prdata,
  output logic                      pready
);
  import gbn_pkg::*;

  // One-hot sequencer. Loading, ranking, then a suppression walk over the ranked list.
  typedef enum logic [16:0] {
    S_LOAD     = 17'h00001,
    S_RK_KEY   = 17'h00002,
    S_RK_CAP   = 17'h00004,
    S_RK_RD    = 17'h00008,
    S_RK_CMP   = 17'h00010,
    S_RK_WR    = 17'h00020,
    S_SUP_TEST = 17'h00040,
    S_PUSH     = 17'h00080,
    S_A_ORD    = 17'h00100,
    S_A_BOX    = 17'h00200,
    S_A_CAP    = 17'h00400,
    S_B_ORD    = 17'h00800,
    S_B_BOX    = 17'h01000,
    S_B_GO     = 17'h02000,
    S_B_WAIT   = 17'h04000,
    S_FLUSH    = 17'h08000,
    S_SUP_RD   = 17'h10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [IOUW-1:0] iou_q;
  logic [KW-1:0]   keep_q;
  logic            sort_q;
  logic [SHW-1:0]  shift_q;

  // Walk counters: cnt is the set size, j the ranked or compared entry, i the candidate,
  // m the entry scanned while ranking.
  logic [CNTW-1:0] cnt_q, i_q, j_q, m_q, emit_q;
  logic [AW-1:0]   rank_q;
  logic [SCW-1:0]  key_q;

  // The pending kept box is held until the next kept box or the end of the walk shows whether
  // it is the final transfer of the set.
  box_t            pend_q;
  logic            pend_valid_q;
  logic [OFW-1:0]  off_q;

  logic            out_valid_q;
  box_t            out_q;
  logic            out_last_q;
  logic            out_free, push;

  // Box memory and rank-to-box index memory, both with registered reads.
  box_t            box_mem [MAXB];
  logic [AW-1:0]   ord_mem [MAXB];
  box_t            box_rd_q;
  logic [AW-1:0]   ord_rd_q;
  logic [AW-1:0]   box_ra, ord_ra;
  logic            box_we, ord_we;
  box_t            in_box;

  // Suppression flags by rank position. The pass of the first kept box (always rank 0)
  // writes every later entry, so stale flags of an earlier set are never seen and rank 0
  // itself is never flagged.
  logic            flag_mem [MAXB];
  logic            flag_rd_q;
  logic            flag_we;
  logic            sup_hit;

  logic            ov_start, ov_done, ov_hit;
  logic            gt;
  logic            cfg_we;

  assign in_box.left   = s_axis_tdata[CW-1:0];
  assign in_box.top    = s_axis_tdata[2*CW-1:CW];
  assign in_box.right  = s_axis_tdata[3*CW-1:2*CW];
  assign in_box.bottom = s_axis_tdata[4*CW-1:3*CW];
  assign in_box.score  = s_axis_tdata[4*CW+SCW-1:4*CW];
  assign in_box.cls    = s_axis_tuser;

  assign s_axis_tready = (state_q == S_LOAD);
  assign box_we = (state_q == S_LOAD) && s_axis_tvalid && (cnt_q < CNTW'(MAXB));
  assign ord_we = (state_q == S_RK_WR);
  assign flag_we = (state_q == S_B_WAIT) && ov_done && (ov_hit || (emit_q == CNTW'(1)));
  assign sup_hit = flag_rd_q && (i_q != '0);

  always_comb begin
    case (state_q)
      S_RK_KEY:         box_ra = j_q[AW-1:0];
      S_RK_RD:          box_ra = m_q[AW-1:0];
      S_A_BOX, S_B_BOX: box_ra = ord_rd_q;
      default:          box_ra = '0;
    endcase
    case (state_q)
      S_A_ORD: ord_ra = i_q[AW-1:0];
      S_B_ORD: ord_ra = j_q[AW-1:0];
      default: ord_ra = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (box_we) begin
      box_mem[cnt_q[AW-1:0]] <= in_box;
    end
    box_rd_q <= box_mem[box_ra];
    if (ord_we) begin
      ord_mem[rank_q] <= j_q[AW-1:0];
    end
    ord_rd_q <= ord_mem[ord_ra];
    if (flag_we) begin
      flag_mem[j_q[AW-1:0]] <= ov_hit;
    end
    flag_rd_q <= flag_mem[i_q[AW-1:0]];
  end

  // Stable descending order: an earlier box with the same score ranks ahead.
  assign gt = (box_rd_q.score > key_q) || ((box_rd_q.score == key_q) && (m_q < j_q));

  assign ov_start = (state_q == S_B_GO);

  gbn_overlap u_overlap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ov_start),
    .a_i     (pend_q),
    .b_i     (box_rd_q),
    .iou_i   (iou_q),
    .done_o  (ov_done),
    .hit_o   (ov_hit)
  );

  assign out_free = !out_valid_q || m_axis_tready;
  assign push = out_free && pend_valid_q && ((state_q == S_PUSH) || (state_q == S_FLUSH));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:     if (s_axis_tvalid && s_axis_tlast) state_d = S_RK_KEY;
      S_RK_KEY:   state_d = sort_q ? S_RK_CAP : S_RK_WR;
      S_RK_CAP:   state_d = S_RK_RD;
      S_RK_RD:    state_d = S_RK_CMP;
      S_RK_CMP:   state_d = (CNTW'(m_q + 1'b1) == cnt_q) ? S_RK_WR : S_RK_RD;
      S_RK_WR:    state_d = (CNTW'(j_q + 1'b1) == cnt_q) ? S_SUP_RD : S_RK_KEY;
      S_SUP_RD:   state_d = S_SUP_TEST;
      S_SUP_TEST: begin
        if (i_q >= cnt_q || emit_q >= keep_q) begin
          state_d = S_FLUSH;
        end else if (!sup_hit) begin
          state_d = pend_valid_q ? S_PUSH : S_A_ORD;
        end else begin
          state_d = S_SUP_RD;
        end
      end
      S_PUSH:     if (out_free) state_d = S_SUP_TEST;
      S_A_ORD:    state_d = S_A_BOX;
      S_A_BOX:    state_d = S_A_CAP;
      S_A_CAP:    state_d = S_B_ORD;
      S_B_ORD:    state_d = (j_q >= cnt_q) ? S_SUP_RD : S_B_BOX;
      S_B_BOX:    state_d = S_B_GO;
      S_B_GO:     state_d = S_B_WAIT;
      S_B_WAIT:   if (ov_done) state_d = S_B_ORD;
      S_FLUSH:    if (!pend_valid_q || out_free) state_d = S_LOAD;
      default:    state_d = S_LOAD;
    endcase
  end

  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      iou_q        <= IOUW'(128);
      keep_q       <= KW'(64);
      sort_q       <= 1'b1;
      shift_q      <= '0;
      cnt_q        <= '0;
      i_q          <= '0;
      j_q          <= '0;
      m_q          <= '0;
      emit_q       <= '0;
      rank_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_IOU:   iou_q   <= pwdata[IOUW-1:0];
          REG_KEEP:  keep_q  <= pwdata[KW-1:0];
          REG_SORT:  sort_q  <= pwdata[0];
          REG_SHIFT: shift_q <= pwdata[SHW-1:0];
          default:   iou_q   <= iou_q;
        endcase
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (box_we) cnt_q <= cnt_q + 1'b1;
          j_q <= '0;
        end
        S_RK_KEY: if (!sort_q) rank_q <= j_q[AW-1:0];
        S_RK_CAP: begin
          m_q    <= '0;
          rank_q <= '0;
        end
        S_RK_CMP: begin
          rank_q <= rank_q + {{(AW-1){1'b0}}, gt};
          m_q    <= m_q + 1'b1;
        end
        S_RK_WR: begin
          j_q    <= j_q + 1'b1;
          i_q    <= '0;
          emit_q <= '0;
        end
        S_SUP_TEST: begin
          if (i_q < cnt_q && emit_q < keep_q && sup_hit) i_q <= i_q + 1'b1;
        end
        S_PUSH: if (out_free) pend_valid_q <= 1'b0;
        S_A_CAP: begin
          pend_valid_q <= 1'b1;
          emit_q       <= emit_q + 1'b1;
          j_q          <= i_q + 1'b1;
        end
        S_B_ORD: if (j_q >= cnt_q) i_q <= i_q + 1'b1;
        S_B_WAIT: begin
          if (ov_done) begin
            j_q <= j_q + 1'b1;
          end
        end
        S_FLUSH: begin
          if (!pend_valid_q || out_free) begin
            pend_valid_q <= 1'b0;
            cnt_q        <= '0;
          end
        end
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Payload registers: the key for ranking, the kept box with its class offset, and the
  // output stage with the offset removed and saturated.
  always_ff @(posedge clk_i) begin
    if (state_q == S_RK_CAP) begin
      key_q <= box_rd_q.score;
    end
    if (state_q == S_A_CAP) begin
      pend_q <= box_rd_q;
      off_q  <= OFW'(box_rd_q.cls) * OFW'(shift_q);
    end
    if (push) begin
      out_q.left   <= sat_sub(pend_q.left, off_q);
      out_q.top    <= sat_sub(pend_q.top, off_q);
      out_q.right  <= sat_sub(pend_q.right, off_q);
      out_q.bottom <= sat_sub(pend_q.bottom, off_q);
      out_q.score  <= pend_q.score;
      out_q.cls    <= pend_q.cls;
      out_last_q   <= (state_q == S_FLUSH);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDW'({out_q.score, out_q.bottom, out_q.right, out_q.top, out_q.left});
  assign m_axis_tuser  = out_q.cls;
  assign m_axis_tlast  = out_last_q;

  assign pready = 1'b1;
  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_IOU:   prdata = PDW'(iou_q);
      REG_KEEP:  prdata = PDW'(keep_q);
      REG_SORT:  prdata = PDW'(sort_q);
      REG_SHIFT: prdata = PDW'(shift_q);
      default:   prdata = '0;
    endcase
  end

`ifndef ASSERT_OFF
  a_load_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !pend_valid_q)
    else $error("set loading started with a kept box still pending");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(MAXB))
    else $error("box count beyond the store depth");
  a_pair_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_B_WAIT && ov_done) |-> (j_q < cnt_q && j_q > i_q))
    else $error("overlap result for an entry outside the walk");
  a_push_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (emit_q != '0 && emit_q <= keep_q))
    else $error("transfer beyond the keep limit");
`endif

endmodule

// File: sv/gbn_overlap.sv
module gbn_overlap (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  gbn_pkg::box_t         a_i,
  input  gbn_pkg::box_t         b_i,
  input  logic [gbn_pkg::IOUW-1:0] iou_i,
  output logic                  done_o,
  output logic                  hit_o
);
  import gbn_pkg::*;

  function automatic logic [CW-1:0] span(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
    logic [CW:0] d;
    d = {hi[CW-1], hi} - {lo[CW-1], lo};
    return (signed'(hi) > signed'(lo)) ? d[CW-1:0] : '0;
  endfunction

  function automatic logic [CW-1:0] smax(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return (signed'(x) > signed'(y)) ? x : y;
  endfunction

  function automatic logic [CW-1:0] smin(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return (signed'(x) < signed'(y)) ? x : y;
  endfunction

  logic [3:0]          v_q;
  logic [CW-1:0]       wa_q, ha_q, wb_q, hb_q, iw_q, ih_q;
  logic [2*CW-1:0]     pi_q, pa_q, pb_q;
  logic [2*CW:0]       uni_q;
  logic [2*CW+7:0]     lhs_q;
  logic                hit_q;
  logic [2*CW+IOUW:0]  rhs;

  assign rhs = (2*CW+IOUW+1)'(uni_q) * (2*CW+IOUW+1)'(iou_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q  <= span(a_i.left, a_i.right);
    ha_q  <= span(a_i.top, a_i.bottom);
    wb_q  <= span(b_i.left, b_i.right);
    hb_q  <= span(b_i.top, b_i.bottom);
    iw_q  <= span(smax(a_i.left, b_i.left), smin(a_i.right, b_i.right));
    ih_q  <= span(smax(a_i.top, b_i.top), smin(a_i.bottom, b_i.bottom));
    pi_q  <= (2*CW)'(iw_q) * (2*CW)'(ih_q);
    pa_q  <= (2*CW)'(wa_q) * (2*CW)'(ha_q);
    pb_q  <= (2*CW)'(wb_q) * (2*CW)'(hb_q);
    uni_q <= (2*CW+1)'(pa_q) + (2*CW+1)'(pb_q) - (2*CW+1)'(pi_q);
    lhs_q <= {pi_q, 8'b0};
    hit_q <= (2*CW+IOUW+1)'(lhs_q) > rhs;
  end

  assign done_o = v_q[3];
  assign hit_o  = hit_q;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import gbn_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic signed [CW-1:0] left;
    logic signed [CW-1:0] top;
    logic signed [CW-1:0] right;
    logic signed [CW-1:0] bottom;
    logic [SCW-1:0]       score;
    logic [CLW-1:0]       cls;
  } det_box_t;

  typedef struct {
    det_box_t bx;
    logic     last;
  } kept_box_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [TDW-1:0]    s_axis_tdata = '0;
  logic [CLW-1:0]    s_axis_tuser = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TDW-1:0]    m_axis_tdata;
  logic [CLW-1:0]    m_axis_tuser;
  logic              m_axis_tlast;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PAW-1:0]    paddr = '0;
  logic [PDW-1:0]    pwdata = '0;
  logic [PDW-1:0]    prdata;
  logic              pready;

  greedy_box_nms_core dut (.*);

  // Shadow of the register file and of the set being loaded.
  logic [IOUW-1:0] iou_r;
  logic [KW-1:0]   keep_r;
  logic            sort_r;
  logic [SHW-1:0]  shift_r;
  det_box_t        set_boxes[$];
  int              last_set_n = 0;

  kept_box_t kept_queue[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_off = 1'b0;
  int        cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver stalls at random, or for as long as the hold-off lasts.
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [63:0] span_of(longint lo, longint hi);
    return (hi > lo) ? 64'(hi - lo) : 64'd0;
  endfunction

  function automatic bit too_close(det_box_t a, det_box_t b);
    longint il, ir, it, ib;
    logic [63:0] inter, area_a, area_b, uni;
    il = (a.left > b.left) ? a.left : b.left;
    ir = (a.right < b.right) ? a.right : b.right;
    it = (a.top > b.top) ? a.top : b.top;
    ib = (a.bottom < b.bottom) ? a.bottom : b.bottom;
    inter  = span_of(il, ir) * span_of(it, ib);
    area_a = span_of(a.left, a.right) * span_of(a.top, a.bottom);
    area_b = span_of(b.left, b.right) * span_of(b.top, b.bottom);
    uni    = area_a + area_b - inter;
    // Exact test: inter/union > iou/256, never true for an empty union.
    return (inter << 8) > (uni * 64'(iou_r));
  endfunction

  function automatic logic [CW-1:0] shift_corner(logic signed [CW-1:0] c, logic [CLW-1:0] cls);
    longint v, hi, lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    v  = longint'(c) - longint'(cls) * longint'(shift_r);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  // Runs sorting, when enabled, and greedy suppression over the finished set and queues the kept boxes.
  task automatic suppress_set();
    int order[MAXB];
    bit gone[MAXB];
    int n, cur, j, emitted;
    kept_box_t kb;
    n = set_boxes.size();
    last_set_n = n;
    for (int i = 0; i < n; i++) begin
      order[i] = i;
      gone[i] = 1'b0;
    end
    if (sort_r) begin
      // Insertion sort keeps equal scores in load order.
      for (int i = 1; i < n; i++) begin
        cur = order[i];
        j = i;
        while (j > 0 && set_boxes[order[j-1]].score < set_boxes[cur].score) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = cur;
      end
    end
    emitted = 0;
    for (int i = 0; i < n && emitted < keep_r; i++) begin
      if (!gone[i]) begin
        for (int k = i + 1; k < n; k++) begin
          if (too_close(set_boxes[order[i]], set_boxes[order[k]])) gone[k] = 1'b1;
        end
        kb.bx = set_boxes[order[i]];
        kb.bx.left   = shift_corner(kb.bx.left, kb.bx.cls);
        kb.bx.top    = shift_corner(kb.bx.top, kb.bx.cls);
        kb.bx.right  = shift_corner(kb.bx.right, kb.bx.cls);
        kb.bx.bottom = shift_corner(kb.bx.bottom, kb.bx.cls);
        kb.last = 1'b0;
        kept_queue.insert(kept_queue.size(), kb);
        emitted++;
      end
    end
    if (emitted > 0) kept_queue[kept_queue.size()-1].last = 1'b1;
    set_boxes.delete();
  endtask

  // Offers one box, with random idle cycles first, and waits for the transfer.
  task automatic send_box(det_box_t bx, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {bx.score, bx.bottom, bx.right, bx.top, bx.left};
    s_axis_tuser  <= bx.cls;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (set_boxes.size() < MAXB) set_boxes.insert(set_boxes.size(), bx);
    if (last) suppress_set();
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every kept box has come out and the block has had time to finish its pass.
  task automatic wait_idle();
    while (kept_queue.size() != 0) @(posedge clk_i);
    repeat (6 * last_set_n * last_set_n + 500) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [PDW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PAW'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_IOU:   iou_r   = value[IOUW-1:0];
      REG_KEEP:  keep_r  = value[KW-1:0];
      REG_SORT:  sort_r  = value[0];
      REG_SHIFT: shift_r = value[SHW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(int iou, int keep, int sort_on, int shift);
    wait_idle();
    write_reg(REG_IOU, iou);
    write_reg(REG_KEEP, keep);
    write_reg(REG_SORT, sort_on);
    write_reg(REG_SHIFT, shift);
  endtask

  function automatic det_box_t make_box(int l, int t, int r, int b, int sc, int cl);
    det_box_t bx;
    bx.left = CW'(l); bx.top = CW'(t); bx.right = CW'(r); bx.bottom = CW'(b);
    bx.score = SCW'(sc); bx.cls = CLW'(cl);
    return bx;
  endfunction

  // Random box: mostly small boxes around a few cluster centers so that overlaps
  // happen, sometimes full-range corners or inverted boxes.
  function automatic det_box_t random_box();
    det_box_t bx;
    int cx, cy, w, h, sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      bx.left = CW'($urandom); bx.top = CW'($urandom);
      bx.right = CW'($urandom); bx.bottom = CW'($urandom);
    end else begin
      cx = 1000 * $urandom_range(3) - 1500 + $urandom_range(60);
      cy = 1000 * $urandom_range(3) - 1500 + $urandom_range(60);
      if (sel < 15) begin
        cx = cx + 8388000 * ($urandom_range(1) ? 1 : -1);
      end
      w = $urandom_range(200);
      h = $urandom_range(200);
      bx.left = CW'(cx - w); bx.right = CW'(cx + w);
      bx.top = CW'(cy - h); bx.bottom = CW'(cy + h);
      if (sel < 20) bx.right = CW'(cx - w - int'($urandom_range(50)));
    end
    bx.score = ($urandom_range(3) == 0) ? 16'(1000 * $urandom_range(3)) : 16'($urandom);
    bx.cls = CLW'($urandom);
    return bx;
  endfunction

  task automatic send_random_set(int n);
    for (int i = 0; i < n; i++) send_box(random_box(), i == n - 1);
  endtask

  // Corner extremes, saturation, ties, zero areas and register extremes but the largest keep limit.
  task automatic test_directed();
    set_config(128, 64, 1, 0);
    send_box(make_box(-8388608, -8388608, 8388607, 8388607, 0, 0), 1'b1);
    send_box(make_box(8388607, 8388607, -8388608, -8388608, 65535, 255), 1'b1);
    // Identical boxes with tied scores fall to an overlapping higher box; a disjoint one survives.
    send_box(make_box(0, 0, 100, 100, 500, 1), 1'b0);
    send_box(make_box(0, 0, 100, 100, 500, 2), 1'b0);
    send_box(make_box(10, 10, 110, 110, 900, 3), 1'b0);
    send_box(make_box(5000, 5000, 5100, 5100, 500, 4), 1'b0);
    send_box(make_box(7, 7, 7, 50, 65535, 5), 1'b1);
    stop_sending();
    // Large class offset saturates the left corner at the low end.
    set_config(255, 1, 0, 32767);
    send_box(make_box(-8388608, 0, 8388607, 10, 3, 255), 1'b0);
    send_box(make_box(-8000000, -10, 8000000, 10, 9, 128), 1'b1);
    stop_sending();
    set_config(0, 2, 0, 1);
    send_box(make_box(0, 0, 10, 10, 1, 200), 1'b0);
    send_box(make_box(9, 9, 20, 20, 2, 7), 1'b0);
    send_box(make_box(100, 100, 120, 120, 3, 9), 1'b1);
    stop_sending();
    // A zero keep limit yields nothing for the set.
    set_config(64, 0, 1, 100);
    send_box(make_box(0, 0, 10, 10, 1, 1), 1'b0);
    send_box(make_box(50, 50, 60, 60, 2, 2), 1'b1);
    stop_sending();
  endtask

  // A set longer than the box memory: the extra boxes are dropped.
  task automatic test_overflow();
    set_config(200, 64, 1, 3);
    send_random_set(MAXB + 2);
    stop_sending();
  endtask

  task automatic test_random(int items, int idle_pct, int stall_pct);
    int sent, n;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    set_config($urandom_range(255), $urandom_range(64), $urandom_range(1),
               ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(40));
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      send_random_set(n);
      sent += n;
    end
    stop_sending();
  endtask

  // The receiver holds off for a long stretch while sets keep coming in.
  task automatic test_backpressure();
    set_config(128, 64, 1, 0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (4000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        for (int s = 0; s < 6; s++) send_random_set(6);
        stop_sending();
      end
    join
  endtask

  // Each output transfer is compared with the oldest kept box.
  always @(posedge clk_i) begin
    kept_box_t kb;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (kept_queue.size() == 0) begin
        $display("%0t: unexpected box, actual %h %h last %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        kb = kept_queue.pop_front();
        if (m_axis_tdata !== {kb.bx.score, kb.bx.bottom, kb.bx.right, kb.bx.top, kb.bx.left}
            || m_axis_tuser !== kb.bx.cls || m_axis_tlast !== kb.last) begin
          $display("%0t: mismatch, expected %h %h last %b, actual %h %h last %b", $time,
                   {kb.bx.score, kb.bx.bottom, kb.bx.right, kb.bx.top, kb.bx.left},
                   kb.bx.cls, kb.last, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    iou_r = 128; keep_r = 64; sort_r = 1'b1; shift_r = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random(60, 0, 0);
    test_random(60, 52, 0);
    test_random(60, 0, 52);
    test_random(60, 36, 36);
    test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: greedy_box_nms_core.f
sv/gbn_pkg.sv
sv/gbn_overlap.sv
sv/greedy_box_nms_core.sv
sim/testbench.sv
